FILE: rtl/mrrc_pkg.sv
// Shared types, codes and the CRC16 byte update for the Modbus RTU response checker.
package mrrc_pkg;

  localparam int FRAME_BYTES_DEF = 21;
  localparam int PAYLOAD_BYTES = 16;
  localparam int PAYLOAD_W = 8 * PAYLOAD_BYTES;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0] FUNC_READ = 8'h03;

  localparam logic [7:0] DEV_ADDR_RST = 8'h50;
  localparam logic [7:0] HERR_LIMIT_RST = 8'd3;
  localparam logic [15:0] FRESH_LIMIT_RST = 16'd500;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_END = 2'd1;
  localparam logic [1:0] CMD_TX_FAIL = 2'd2;
  localparam logic [1:0] CMD_RX_FAIL = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_TX = 3'd1;
  localparam logic [2:0] ST_RX = 3'd2;
  localparam logic [2:0] ST_LEN = 3'd3;
  localparam logic [2:0] ST_HDR = 3'd4;
  localparam logic [2:0] ST_CRC = 3'd5;
  localparam logic [2:0] ST_TIMEOUT = 3'd6;

  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_HERR_LIMIT = 2'd1;
  localparam logic [1:0] REG_FRESH_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] longitude_raw;
    logic [31:0] latitude_raw;
    logic [15:0] altitude_raw;
    logic [15:0] heading_raw;
    logic [31:0] speed_raw;
    logic [7:0] header_error_count;
  } out_item_t;

  typedef struct packed {
    logic len_ok;
    logic header_good;
    logic crc_match;
  } rx_status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/mrrc_receiver.sv
// Frame receiver: byte counter, running CRC16, header check and payload staging.
module mrrc_receiver import mrrc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_en,
  input  logic                 restart,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           device_address,
  output rx_status_t           rx_status,
  output logic [PAYLOAD_W-1:0] staged_payload
);

  localparam int CW = $clog2(FRAME_BYTES + 1);

  logic [CW-1:0]        byte_count_r, byte_count_nxt;
  logic [15:0]          running_crc_r, running_crc_nxt;
  logic                 header_good_r, header_good_nxt;
  logic                 overflow_r, overflow_nxt;
  logic [15:0]          received_crc_r, received_crc_nxt;
  logic [PAYLOAD_W-1:0] staged_r, staged_nxt;
  logic [7:0]           idx8;

  assign idx8 = 8'(byte_count_r);

  always_comb begin
    byte_count_nxt = byte_count_r;
    running_crc_nxt = running_crc_r;
    header_good_nxt = header_good_r;
    overflow_nxt = overflow_r;
    received_crc_nxt = received_crc_r;
    staged_nxt = staged_r;
    if (restart) begin
      byte_count_nxt = '0;
      running_crc_nxt = CRC_INIT;
      header_good_nxt = 1'b1;
      overflow_nxt = 1'b0;
      received_crc_nxt = '0;
      staged_nxt = '0;
    end else if (byte_en) begin
      if (byte_count_r >= CW'(FRAME_BYTES)) begin
        overflow_nxt = 1'b1;
      end else begin
        if (idx8 == 8'd0 && data_byte != device_address) begin
          header_good_nxt = 1'b0;
        end
        if (idx8 == 8'd1 && data_byte != FUNC_READ) begin
          header_good_nxt = 1'b0;
        end
        if (idx8 == 8'd2 && data_byte != 8'(FRAME_BYTES - 5)) begin
          header_good_nxt = 1'b0;
        end
        if (byte_count_r < CW'(FRAME_BYTES - 2)) begin
          running_crc_nxt = crc16_byte(running_crc_r, data_byte);
          for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (idx8 == 8'(k + 3)) begin
              staged_nxt[PAYLOAD_W-1-8*k -: 8] = data_byte;
            end
          end
        end else if (byte_count_r == CW'(FRAME_BYTES - 2)) begin
          received_crc_nxt = {received_crc_r[15:8], data_byte};
        end else begin
          received_crc_nxt = {data_byte, received_crc_r[7:0]};
        end
        byte_count_nxt = byte_count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      running_crc_r <= CRC_INIT;
      header_good_r <= 1'b1;
      overflow_r <= 1'b0;
      received_crc_r <= '0;
      staged_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      running_crc_r <= running_crc_nxt;
      header_good_r <= header_good_nxt;
      overflow_r <= overflow_nxt;
      received_crc_r <= received_crc_nxt;
      staged_r <= staged_nxt;
    end
  end

  assign rx_status.len_ok = !overflow_r && (byte_count_r == CW'(FRAME_BYTES));
  assign rx_status.header_good = header_good_r;
  assign rx_status.crc_match = (running_crc_r == received_crc_r);
  assign staged_payload = staged_r;

endmodule

FILE: rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: input stage, frame verdict and result register.
// A frame-end or failure item is registered in the input stage at acceptance, and its result is
// registered in the result register when that item leaves the input stage.
// Throughput: one item per cycle; data bytes produce no result and never stall.
// A result item stalls the input stage only while the result register is still full.
// Reset (rst_n, synchronous, active low) empties both stages, restores the register defaults
// and clears the receiver, the held position data, the success time and the error count.
module modbus_rtu_response_checker import mrrc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]           dev_addr_r;
  logic [7:0]           herr_limit_r;
  logic [15:0]          fresh_limit_r;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  logic                 s1_valid_r;
  in_item_t             s1_r;
  logic                 s1_is_byte;
  logic                 s1_advance;
  logic                 out_free;

  logic                 out_valid_r;
  out_item_t            out_r;

  rx_status_t           rx_status;
  logic [PAYLOAD_W-1:0] staged_payload;
  logic                 byte_en;
  logic                 restart;

  logic [PAYLOAD_W-1:0] held_r, held_nxt;
  logic [31:0]          last_ok_r, last_ok_nxt;
  logic [7:0]           herr_r, herr_nxt;
  logic [2:0]           base_status;
  logic [2:0]           status_nxt;
  logic                 final_verdict;
  logic [31:0]          age;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[3:2];

  always_comb begin
    unique case (cfg_idx)
      REG_DEV_ADDR:    cfg_prdata = {24'd0, dev_addr_r};
      REG_HERR_LIMIT:  cfg_prdata = {24'd0, herr_limit_r};
      REG_FRESH_LIMIT: cfg_prdata = {16'd0, fresh_limit_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
      herr_limit_r <= HERR_LIMIT_RST;
      fresh_limit_r <= FRESH_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEV_ADDR:    dev_addr_r <= cfg_pwdata[7:0];
        REG_HERR_LIMIT:  herr_limit_r <= cfg_pwdata[7:0];
        REG_FRESH_LIMIT: fresh_limit_r <= cfg_pwdata[15:0];
        default:         ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign s1_is_byte = (s1_r.command == CMD_BYTE);
  assign s1_advance = s1_valid_r && (s1_is_byte || out_free);
  assign in_ready = !s1_valid_r || s1_advance;
  assign byte_en = s1_advance && s1_is_byte;
  assign restart = s1_advance && !s1_is_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  mrrc_receiver #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_receiver (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_en        (byte_en),
    .restart        (restart),
    .data_byte      (s1_r.data_byte),
    .device_address (dev_addr_r),
    .rx_status      (rx_status),
    .staged_payload (staged_payload)
  );

  always_comb begin
    case (s1_r.command)
      CMD_TX_FAIL: base_status = ST_TX;
      CMD_RX_FAIL: base_status = ST_RX;
      default: begin
        if (!rx_status.len_ok) begin
          base_status = ST_LEN;
        end else if (!rx_status.header_good) begin
          base_status = ST_HDR;
        end else if (!rx_status.crc_match) begin
          base_status = ST_CRC;
        end else begin
          base_status = ST_OK;
        end
      end
    endcase
  end

  assign age = s1_r.now_ms - last_ok_r;

  always_comb begin
    held_nxt = held_r;
    last_ok_nxt = last_ok_r;
    herr_nxt = herr_r;
    final_verdict = 1'b0;
    if (base_status == ST_OK) begin
      held_nxt = staged_payload;
      last_ok_nxt = s1_r.now_ms;
      herr_nxt = 8'd0;
      final_verdict = 1'b1;
    end else if (base_status == ST_HDR) begin
      if (herr_r != 8'hFF) begin
        herr_nxt = herr_r + 8'd1;
      end
      final_verdict = (herr_nxt > herr_limit_r);
    end
    status_nxt = base_status;
    if (!final_verdict && age > {16'd0, fresh_limit_r}) begin
      status_nxt = ST_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      last_ok_r <= '0;
      herr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (restart) begin
        held_r <= held_nxt;
        last_ok_r <= last_ok_nxt;
        herr_r <= herr_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      out_r.status <= status_nxt;
      out_r.longitude_raw <= {held_nxt[111:96], held_nxt[127:112]};
      out_r.latitude_raw <= {held_nxt[79:64], held_nxt[95:80]};
      out_r.altitude_raw <= held_nxt[63:48];
      out_r.heading_raw <= held_nxt[47:32];
      out_r.speed_raw <= {held_nxt[15:0], held_nxt[31:16]};
      out_r.header_error_count <= herr_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_ok_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_OK |-> out_r.header_error_count == 8'd0)
    else $error("success result with nonzero header error count");

  a_hdr_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ST_HDR |-> out_r.header_error_count != 8'd0)
    else $error("header error result without a counted error");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && !s1_is_byte && out_valid_r && !out_ready)
    else $error("input stalled without a full result register");

  a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    byte_en |=> !(out_valid_r && !$past(out_valid_r)))
    else $error("data byte produced a result");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the Modbus RTU response checker: stimulus, predictor, scoreboard.
module testbench import mrrc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {
    FLAW_NONE, FLAW_ADDR, FLAW_FUNC, FLAW_COUNT, FLAW_CRC, FLAW_SHORT, FLAW_LONG, FLAW_ABORT
  } flaw_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  in_item_t link_items[$];
  out_item_t verdicts_due[$];
  int items_queued = 0;
  int send_gap_pct = 30;
  int recv_gap_pct = 66;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;
  logic [31:0] clock_ms = '0;

  logic [7:0] cfg_addr = DEV_ADDR_RST;
  logic [7:0] cfg_herr_limit = HERR_LIMIT_RST;
  logic [15:0] cfg_fresh = FRESH_LIMIT_RST;

  logic [4:0] rx_count = '0;
  logic [15:0] rx_crc = CRC_INIT;
  logic rx_hdr_ok = 1'b1;
  logic rx_overflow = 1'b0;
  logic [15:0] rx_crc_sent = '0;
  logic [PAYLOAD_W-1:0] rx_payload = '0;
  logic [PAYLOAD_W-1:0] fix_payload = '0;
  logic [31:0] fix_time_ms = '0;
  logic [7:0] hdr_err_run = '0;

  modbus_rtu_response_checker dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] held_word(input int k);
    return fix_payload[PAYLOAD_W-1-8*k -: 16];
  endfunction

  task automatic predict_verdict(input in_item_t it);
    out_item_t want;
    logic [2:0] code;
    logic settled;
    int idx;
    idx = rx_count;
    if (it.command == CMD_BYTE) begin
      if (idx >= FRAME_BYTES_DEF) begin
        rx_overflow = 1'b1;
      end else begin
        if (idx == 0 && it.data_byte != cfg_addr) rx_hdr_ok = 1'b0;
        if (idx == 1 && it.data_byte != FUNC_READ) rx_hdr_ok = 1'b0;
        if (idx == 2 && it.data_byte != 8'(FRAME_BYTES_DEF - 5)) rx_hdr_ok = 1'b0;
        if (idx < FRAME_BYTES_DEF - 2) begin
          rx_crc = crc16_next(rx_crc, it.data_byte);
          if (idx >= 3 && idx - 3 < PAYLOAD_BYTES) begin
            rx_payload[PAYLOAD_W-1-8*(idx-3) -: 8] = it.data_byte;
          end
        end else if (idx == FRAME_BYTES_DEF - 2) begin
          rx_crc_sent[7:0] = it.data_byte;
        end else begin
          rx_crc_sent[15:8] = it.data_byte;
        end
        rx_count = 5'(idx + 1);
      end
    end else begin
      case (it.command)
        CMD_TX_FAIL: code = ST_TX;
        CMD_RX_FAIL: code = ST_RX;
        default: begin
          if (rx_overflow || rx_count != FRAME_BYTES_DEF) code = ST_LEN;
          else if (!rx_hdr_ok) code = ST_HDR;
          else if (rx_crc != rx_crc_sent) code = ST_CRC;
          else code = ST_OK;
        end
      endcase
      settled = 1'b0;
      if (code == ST_OK) begin
        fix_payload = rx_payload;
        fix_time_ms = it.now_ms;
        hdr_err_run = '0;
        settled = 1'b1;
      end else if (code == ST_HDR) begin
        if (hdr_err_run != 8'hFF) hdr_err_run = hdr_err_run + 8'd1;
        if (hdr_err_run > cfg_herr_limit) settled = 1'b1;
      end
      if (!settled && (it.now_ms - fix_time_ms) > {16'h0000, cfg_fresh}) code = ST_TIMEOUT;
      rx_count = '0;
      rx_crc = CRC_INIT;
      rx_hdr_ok = 1'b1;
      rx_overflow = 1'b0;
      rx_crc_sent = '0;
      rx_payload = '0;
      want.status = code;
      want.longitude_raw = {held_word(2), held_word(0)};
      want.latitude_raw = {held_word(6), held_word(4)};
      want.altitude_raw = held_word(8);
      want.heading_raw = held_word(10);
      want.speed_raw = {held_word(14), held_word(12)};
      want.header_error_count = hdr_err_run;
      verdicts_due.push_back(want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_verdict(in_data);
      if (!in_valid || in_ready) begin
        if (link_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data <= link_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing expected: st=%0d herr=%0d",
                   results_seen, out_data.status, out_data.header_error_count);
        end
      end else begin
        want = verdicts_due.pop_front();
        if (out_data.status !== want.status ||
            out_data.longitude_raw !== want.longitude_raw ||
            out_data.latitude_raw !== want.latitude_raw ||
            out_data.altitude_raw !== want.altitude_raw ||
            out_data.heading_raw !== want.heading_raw ||
            out_data.speed_raw !== want.speed_raw ||
            out_data.header_error_count !== want.header_error_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d expected st=%0d lon=%h lat=%h alt=%h hdg=%h spd=%h herr=%0d",
                     results_seen, want.status, want.longitude_raw, want.latitude_raw,
                     want.altitude_raw, want.heading_raw, want.speed_raw,
                     want.header_error_count);
            $display("result %0d actual   st=%0d lon=%h lat=%h alt=%h hdg=%h spd=%h herr=%0d",
                     results_seen, out_data.status, out_data.longitude_raw,
                     out_data.latitude_raw, out_data.altitude_raw, out_data.heading_raw,
                     out_data.speed_raw, out_data.header_error_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] next_stamp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) clock_ms = clock_ms + $urandom_range(0, 1);
    else if (r < 65) clock_ms = clock_ms + $urandom_range(2, 400);
    else if (r < 88) clock_ms = clock_ms + $urandom_range(400, 1500);
    else if (r < 96) clock_ms = clock_ms + $urandom_range(1500, 80000);
    else clock_ms = $urandom;
    return clock_ms;
  endfunction

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] b, input logic [31:0] ms);
    in_item_t it;
    it.command = cmd;
    it.data_byte = b;
    it.now_ms = ms;
    link_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_frame(input flaw_t flaw, input logic [31:0] end_ms);
    logic [7:0] body[$];
    logic [15:0] sum;
    int pick;
    body.push_back(cfg_addr);
    body.push_back(FUNC_READ);
    body.push_back(8'(FRAME_BYTES_DEF - 5));
    repeat (PAYLOAD_BYTES) body.push_back(8'($urandom));
    case (flaw)
      FLAW_ADDR: body[0] = body[0] ^ 8'($urandom_range(1, 255));
      FLAW_FUNC: body[1] = body[1] ^ 8'($urandom_range(1, 255));
      FLAW_COUNT: body[2] = body[2] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    sum = CRC_INIT;
    foreach (body[i]) sum = crc16_next(sum, body[i]);
    body.push_back(sum[7:0]);
    body.push_back(sum[15:8]);
    case (flaw)
      FLAW_CRC: begin
        pick = $urandom_range(3, FRAME_BYTES_DEF - 1);
        body[pick] = body[pick] ^ (8'd1 << $urandom_range(0, 7));
      end
      FLAW_SHORT: begin
        pick = $urandom_range(0, FRAME_BYTES_DEF - 1);
        while (body.size() > pick) void'(body.pop_back());
      end
      FLAW_ABORT: begin
        pick = $urandom_range(0, FRAME_BYTES_DEF);
        while (body.size() > pick) void'(body.pop_back());
      end
      FLAW_LONG: repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
      default: ;
    endcase
    foreach (body[i]) push_item(CMD_BYTE, body[i], $urandom);
    if (flaw == FLAW_ABORT) begin
      push_item($urandom_range(0, 1) ? CMD_TX_FAIL : CMD_RX_FAIL, 8'($urandom), end_ms);
    end else begin
      push_item(CMD_END, 8'($urandom), end_ms);
    end
  endtask

  task automatic queue_traffic(input int n);
    int target;
    int unsigned r;
    target = items_queued + n;
    while (items_queued < target) begin
      r = $urandom_range(99);
      if (r < 45) queue_frame(FLAW_NONE, next_stamp());
      else if (r < 50) queue_frame(FLAW_ADDR, next_stamp());
      else if (r < 53) queue_frame(FLAW_FUNC, next_stamp());
      else if (r < 56) queue_frame(FLAW_COUNT, next_stamp());
      else if (r < 65) queue_frame(FLAW_CRC, next_stamp());
      else if (r < 72) queue_frame(FLAW_SHORT, next_stamp());
      else if (r < 79) queue_frame(FLAW_LONG, next_stamp());
      else if (r < 89) queue_frame(FLAW_ABORT, next_stamp());
      else begin
        repeat ($urandom_range(1, 3)) push_item(2'($urandom), 8'($urandom), next_stamp());
      end
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    while (link_items.size() != 0 || in_valid || verdicts_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] reg_sel, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (reg_sel)
      REG_DEV_ADDR: cfg_addr = value[7:0];
      REG_HERR_LIMIT: cfg_herr_limit = value[7:0];
      REG_FRESH_LIMIT: cfg_fresh = value[15:0];
      default: ;
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_item(CMD_END, 8'h00, 32'd0);
    push_item(CMD_TX_FAIL, 8'hFF, 32'd500);
    push_item(CMD_RX_FAIL, 8'h00, 32'd501);
    queue_frame(FLAW_NONE, 32'hFFFF_FFFF);
    push_item(CMD_RX_FAIL, 8'hA5, 32'd0);
    clock_ms = 32'hFFFF_FF00;
    queue_traffic(200);
    wait_quiet();
    queue_traffic(200);
    wait_quiet();

    send_gap_pct = 66;
    recv_gap_pct = 30;
    write_reg(REG_DEV_ADDR, 32'h0000_0000);
    write_reg(REG_HERR_LIMIT, 32'h0000_0000);
    write_reg(REG_FRESH_LIMIT, 32'h0000_0000);
    queue_traffic(350);
    wait_quiet();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_reg(REG_DEV_ADDR, 32'h0000_00FF);
    write_reg(REG_HERR_LIMIT, 32'h0000_00FF);
    write_reg(REG_FRESH_LIMIT, 32'h0000_FFFF);
    queue_traffic(200);
    repeat (8) queue_frame(FLAW_ADDR, next_stamp());
    wait_quiet();

    write_reg(REG_HERR_LIMIT, 32'h0000_0004);
    repeat (3) queue_frame(FLAW_ADDR, next_stamp());
    queue_traffic(100);
    wait_quiet();

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mrrc_pkg.sv
rtl/mrrc_receiver.sv
rtl/modbus_rtu_response_checker.sv
sim/testbench.sv
